// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the decoder top file. All checks are sampled on clk
// and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/srfd_pkg.sv =====
// ----------------------------------------------------------------------------
// srfd_pkg
// Types and constants of the SLIP response frame decoder.
// ----------------------------------------------------------------------------
package srfd_pkg;

    localparam int BUFFER_BYTES = 64;

    localparam logic [7:0] MARK_END     = 8'hC0;
    localparam logic [7:0] MARK_ESC     = 8'hDB;
    localparam logic [7:0] MARK_ESC_END = 8'hDC;
    localparam logic [7:0] DIR_RESPONSE = 8'h01;
    localparam logic [7:0] STATUS_NONE  = 8'hFF;
    localparam logic [7:0] STATUS_OK    = 8'h00;

    // Frame byte positions that the verdict depends on.
    localparam logic [6:0] MIN_LENGTH   = 7'd8;
    localparam logic [6:0] STATUS_POS   = 7'd8;
    localparam logic [6:0] STATUS_NEED  = 7'd9;
    localparam logic [6:0] BUFFER_LIMIT = 7'(BUFFER_BYTES);

    typedef enum logic [1:0] {
        REQ_ARM    = 2'd0,
        REQ_BYTE   = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_UNUSED = 2'd3
    } req_code_t;

    typedef enum logic [0:0] {
        KIND_DATA    = 1'b0,
        KIND_VERDICT = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        FAIL_NONE       = 3'd0,
        FAIL_NO_START   = 3'd1,
        FAIL_SHORT      = 3'd2,
        FAIL_DIRECTION  = 3'd3,
        FAIL_NO_STATUS  = 3'd4,
        FAIL_BAD_STATUS = 3'd5
    } fail_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_HUNT  = 2'd1,
        PH_FRAME = 2'd2
    } phase_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  rx_byte;
        logic [15:0] timeout_ticks;
    } req_t;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] data_byte;
        logic [5:0] byte_index;
        logic       frame_ok;
        logic [2:0] fail_reason;
        logic [6:0] frame_length;
        logic [7:0] status_value;
    } rsp_t;

endpackage

// ===== rtl/slip_response_frame_decoder_top.sv =====
// ----------------------------------------------------------------------------
// slip_response_frame_decoder_top
// Decodes one SLIP-framed response: hunts for the start marker, unescapes
// the frame bytes, reports each stored byte and a final verdict.
// ----------------------------------------------------------------------------
// The decoder takes one request word per clock while not stalled (arm,
// received byte or timer tick) and returns at most one result word for it.
// The request is held in an input register, then the decode step and the
// state update run combinationally and load the result register, which
// presents the result word. A full result register that is not being taken
// stalls the input register, and the request side keeps accepting as long
// as the input register is empty or moving on. There is no clearing pass
// after reset.
`default_nettype none

module slip_response_frame_decoder_top (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    input  wire srfd_pkg::req_t  req,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output srfd_pkg::rsp_t       rsp
);
    import srfd_pkg::*;

    // Input register.
    logic   in_valid_reg;
    req_t   in_reg;

    // Decoder state.
    phase_t      phase_reg,     phase_next;
    logic        esc_reg,       esc_next;
    logic [6:0]  count_reg,     count_next;
    logic [7:0]  dir_reg,       dir_next;
    logic [7:0]  status_reg,    status_next;
    logic [15:0] ticks_reg,     ticks_next;

    // Result register.
    logic   out_valid_reg;
    rsp_t   out_reg;

    logic        step;
    logic        stage_ready;
    logic        has_result;
    rsp_t        result;
    logic [7:0]  byte_value;
    logic        store_room;
    logic [15:0] ticks_dec;
    logic [7:0]  verdict_status;
    fail_t       verdict_reason;

    assign stage_ready = !out_valid_reg || rsp_ready;
    assign step        = in_valid_reg && stage_ready;
    assign req_ready   = !in_valid_reg || stage_ready;
    assign rsp_valid   = out_valid_reg;
    assign rsp         = out_reg;

    // Unescaped value of the received byte; it differs from the byte only when an escape is pending.
    assign byte_value = esc_reg ? ((in_reg.rx_byte == MARK_ESC_END) ? MARK_END : MARK_ESC)
                                : in_reg.rx_byte;
    assign store_room = (count_reg < BUFFER_LIMIT);
    assign ticks_dec  = (ticks_reg != 16'd0) ? (ticks_reg - 16'd1) : 16'd0;

    always_comb
    begin
        verdict_status = (count_reg >= STATUS_NEED) ? status_reg : STATUS_NONE;
        if (count_reg < MIN_LENGTH)
            verdict_reason = FAIL_SHORT;
        else if (dir_reg != DIR_RESPONSE)
            verdict_reason = FAIL_DIRECTION;
        else if (count_reg < STATUS_NEED)
            verdict_reason = FAIL_NO_STATUS;
        else if (verdict_status != STATUS_OK)
            verdict_reason = FAIL_BAD_STATUS;
        else
            verdict_reason = FAIL_NONE;
    end

    // Next state of the decoder.
    always_comb
    begin
        phase_next  = phase_reg;
        esc_next    = esc_reg;
        count_next  = count_reg;
        dir_next    = dir_reg;
        status_next = status_reg;
        ticks_next  = ticks_reg;
        case (req_code_t'(in_reg.req_type))
            REQ_ARM:
            begin
                phase_next  = PH_HUNT;
                esc_next    = 1'b0;
                count_next  = 7'd0;
                dir_next    = 8'h00;
                status_next = STATUS_NONE;
                ticks_next  = in_reg.timeout_ticks;
            end
            REQ_TICK:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    ticks_next = ticks_dec;
                    if (ticks_dec == 16'd0)
                    begin
                        phase_next = PH_IDLE;
                        esc_next   = 1'b0;
                    end
                end
            end
            REQ_BYTE:
            begin
                if (phase_reg == PH_HUNT)
                begin
                    if (in_reg.rx_byte == MARK_END)
                        phase_next = PH_FRAME;
                end
                else if (phase_reg == PH_FRAME)
                begin
                    if (in_reg.rx_byte == MARK_END)
                    begin
                        phase_next = PH_IDLE;
                        esc_next   = 1'b0;
                    end
                    else if (!esc_reg && in_reg.rx_byte == MARK_ESC)
                        esc_next = 1'b1;
                    else
                    begin
                        esc_next = 1'b0;
                        if (store_room)
                        begin
                            if (count_reg == 7'd0)
                                dir_next = byte_value;
                            if (count_reg == STATUS_POS)
                                status_next = byte_value;
                            count_next = count_reg + 7'd1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Result word of the decode step.
    always_comb
    begin
        has_result = 1'b0;
        result     = '0;
        case (req_code_t'(in_reg.req_type))
            REQ_TICK:
            begin
                if (phase_reg != PH_IDLE && ticks_dec == 16'd0)
                begin
                    has_result         = 1'b1;
                    result.result_kind = KIND_VERDICT;
                    if (phase_reg == PH_HUNT)
                    begin
                        result.fail_reason  = FAIL_NO_START;
                        result.status_value = STATUS_NONE;
                    end
                    else
                    begin
                        result.frame_ok     = (verdict_reason == FAIL_NONE);
                        result.fail_reason  = verdict_reason;
                        result.frame_length = count_reg;
                        result.status_value = verdict_status;
                    end
                end
            end
            REQ_BYTE:
            begin
                if (phase_reg == PH_FRAME)
                begin
                    if (in_reg.rx_byte == MARK_END)
                    begin
                        has_result          = 1'b1;
                        result.result_kind  = KIND_VERDICT;
                        result.frame_ok     = (verdict_reason == FAIL_NONE);
                        result.fail_reason  = verdict_reason;
                        result.frame_length = count_reg;
                        result.status_value = verdict_status;
                    end
                    else if ((esc_reg || in_reg.rx_byte != MARK_ESC) && store_room)
                    begin
                        has_result         = 1'b1;
                        result.result_kind = KIND_DATA;
                        result.data_byte   = byte_value;
                        result.byte_index  = count_reg[5:0];
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            esc_reg       <= 1'b0;
            count_reg     <= 7'd0;
            dir_reg       <= 8'h00;
            status_reg    <= STATUS_NONE;
            ticks_reg     <= 16'd0;
        end
        else
        begin
            if (req_ready)
                in_valid_reg <= req_valid;
            if (stage_ready)
                out_valid_reg <= step && has_result;
            if (step)
            begin
                phase_reg  <= phase_next;
                esc_reg    <= esc_next;
                count_reg  <= count_next;
                dir_reg    <= dir_next;
                status_reg <= status_next;
                ticks_reg  <= ticks_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            in_reg <= req;
        if (step && has_result)
            out_reg <= result;
    end

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_count_bound, count_reg <= BUFFER_LIMIT, "stored count past buffer size")
    `ASSERT_IMPLIES(a_esc_in_frame, esc_reg, phase_reg == PH_FRAME,
                    "escape pending outside a frame")
    `ASSERT_IMPLIES(a_verdict_ok, out_valid_reg && out_reg.result_kind == KIND_VERDICT,
                    out_reg.frame_ok == (out_reg.fail_reason == FAIL_NONE),
                    "verdict flag disagrees with reason")
    `ASSERT_NEXT(a_stall_holds_state, in_valid_reg && out_valid_reg && !rsp_ready,
                 $stable(count_reg) && $stable(phase_reg) && in_valid_reg,
                 "decoder advanced while result stalled")

endmodule

`default_nettype wire
